### src/smf_pkg.sv
// Shared types and constants for the sliding median filter.
`timescale 1ns / 1ps
`default_nettype none

package smf_pkg;

  localparam int SMF_WINDOW   = 5;   // default window length
  localparam int SMF_DATA_W   = 16;  // Q3.12 sample width
  localparam int SMF_AGE_W    = 4;   // holds ages up to the largest window
  localparam int SMF_FILL_W   = 4;   // fill count, saturates at the window length
  localparam int SMF_FLUSH_W  = 3;   // trailing zero shifts, at most seven

  // What one cell shows its neighbors.
  typedef struct packed {
    logic signed [SMF_DATA_W-1:0] value;
    logic [SMF_AGE_W-1:0]         age;
    logic                         le;   // value <= incoming sample
    logic                         dl;   // oldest entry sits here or to the left
  } cell_link_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } smf_state_e;

endpackage

`default_nettype wire

### src/sliding_median_filter.sv
// Top level of the sliding median filter: control, fill tracking and result register.
`timescale 1ns / 1ps
`default_nettype none

// Median filter over a column of signed Q3.12 samples, zero padded at both
// ends. The window is a row of WINDOW sorted cells; each accepted sample is
// inserted and the oldest entry dropped in the same shift, and the median of
// the new window is then registered once the result side is free. Ordinary
// items are taken one per cycle while the result side keeps up. The item
// flagged column_last (LAG = WINDOW - 1 - WINDOW/2) holds off new items while
// the cells shift in LAG zeros one per cycle, under the same condition, to
// flush the pending positions, and clear for the next column. Results lag
// the input by LAG items; n samples give n results, the last marked column_end.

module sliding_median_filter import smf_pkg::*; #(
  parameter int WINDOW = SMF_WINDOW
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic signed [SMF_DATA_W-1:0] sample_i,
  input  wire logic                         column_last_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic signed [SMF_DATA_W-1:0]      filtered_o,
  output logic                              run_last_o,
  output logic                              column_end_o
);

  localparam int LAG = WINDOW - 1 - WINDOW / 2;

  smf_state_e                   state_q, state_d;
  logic [SMF_FILL_W-1:0]        fill_q, fill_d, fill_next;
  logic [SMF_FLUSH_W-1:0]       flush_q, flush_d;
  logic                         emit_q, emit_d;
  logic                         last_q, last_d;
  logic                         out_valid_q, out_valid_d;
  logic signed [SMF_DATA_W-1:0] filtered_q;
  logic                         run_last_q, column_end_q;

  logic                         out_free, step_go, run_done, accept;
  logic                         flush_shift, shift, clear, load_out;
  logic signed [SMF_DATA_W-1:0] shift_val, median;

  assign out_free = !out_valid_q || !out_stall_i;
  assign step_go  = (state_q == ST_RUN) && (!emit_q || out_free);
  assign run_done = step_go && (flush_q == '0);

  assign in_stall_o = !((state_q == ST_IDLE) || (run_done && !last_q));
  assign accept     = in_valid_i && !in_stall_o;

  assign flush_shift = step_go && (flush_q != '0);
  assign shift       = accept || flush_shift;
  assign shift_val   = accept ? sample_i : '0;
  assign clear       = run_done && last_q;
  assign load_out    = step_go && emit_q;

  assign fill_next = (fill_q < SMF_FILL_W'(WINDOW)) ? fill_q + SMF_FILL_W'(1) : fill_q;

  smf_chain #(
    .WINDOW (WINDOW)
  ) u_chain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .shift_i  (shift),
    .clear_i  (clear),
    .sample_i (shift_val),
    .median_o (median)
  );

  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    flush_d = flush_q;
    emit_d  = emit_q;
    last_d  = last_q;

    if (load_out) begin
      emit_d = 1'b0;
    end
    if (clear) begin
      fill_d = '0;
    end
    if (run_done) begin
      state_d = ST_IDLE;
    end
    if (flush_shift) begin
      fill_d  = fill_next;
      emit_d  = (fill_next > SMF_FILL_W'(LAG));
      flush_d = flush_q - SMF_FLUSH_W'(1);
    end
    if (accept) begin
      state_d = ST_RUN;
      fill_d  = fill_next;
      emit_d  = (fill_next > SMF_FILL_W'(LAG));
      last_d  = column_last_i;
      flush_d = column_last_i ? SMF_FLUSH_W'(LAG) : '0;
    end
  end

  assign out_valid_d = load_out ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      flush_q     <= '0;
      emit_q      <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      flush_q     <= flush_d;
      emit_q      <= emit_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      filtered_q   <= median;
      run_last_q   <= (flush_q == '0);
      column_end_q <= last_q && (flush_q == '0);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign filtered_o   = filtered_q;
  assign run_last_o   = run_last_q;
  assign column_end_o = column_end_q;

  a_no_accept_in_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (flush_q == '0))
    else $error("sliding_median_filter: item taken during flush");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= SMF_FILL_W'(WINDOW))
    else $error("sliding_median_filter: fill count beyond window");

  a_emit_needs_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_q |-> (fill_q > SMF_FILL_W'(LAG)))
    else $error("sliding_median_filter: result pending before window filled");

  a_clear_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear |=> (fill_q == '0) && (state_q == ST_IDLE))
    else $error("sliding_median_filter: column end did not clear state");

endmodule

`default_nettype wire

### src/smf_cell.sv
// One cell of the sorted window: a value and its age, re-sorted on every shift.
`timescale 1ns / 1ps
`default_nettype none

module smf_cell import smf_pkg::*; #(
  parameter int WINDOW = SMF_WINDOW,
  parameter int IDX    = 0
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         shift_i,
  input  wire logic                         clear_i,
  input  wire logic signed [SMF_DATA_W-1:0] sample_i,
  input  wire cell_link_t                   left_i,
  input  wire cell_link_t                   right_i,
  output cell_link_t                        link_o
);

  logic signed [SMF_DATA_W-1:0] value_q, value_d;
  logic [SMF_AGE_W-1:0]         age_q, age_d;
  logic                         le, is_old, dl;
  logic                         rem_le, rem_gt;

  assign le     = (value_q <= sample_i);
  assign is_old = (age_q == SMF_AGE_W'(WINDOW - 1));
  assign dl     = left_i.dl | is_old;

  // Entry i of the window with the oldest removed lies at or below the sample
  assign rem_le = dl ? right_i.le : le;
  // Entry i-1 of that reduced window lies above the sample
  assign rem_gt = left_i.dl ? !le : !left_i.le;

  always_comb begin
    if (rem_le) begin
      if (dl) begin
        value_d = right_i.value;
        age_d   = right_i.age + SMF_AGE_W'(1);
      end else begin
        value_d = value_q;
        age_d   = age_q + SMF_AGE_W'(1);
      end
    end else if (rem_gt) begin
      if (left_i.dl) begin
        value_d = value_q;
        age_d   = age_q + SMF_AGE_W'(1);
      end else begin
        value_d = left_i.value;
        age_d   = left_i.age + SMF_AGE_W'(1);
      end
    end else begin
      value_d = sample_i;
      age_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
      age_q   <= SMF_AGE_W'(IDX);
    end else if (clear_i) begin
      value_q <= '0;
      age_q   <= SMF_AGE_W'(IDX);
    end else if (shift_i) begin
      value_q <= value_d;
      age_q   <= age_d;
    end
  end

  assign link_o.value = value_q;
  assign link_o.age   = age_q;
  assign link_o.le    = le;
  assign link_o.dl    = dl;

endmodule

`default_nettype wire

### src/smf_chain.sv
// Row of sorted cells holding the window, with the median tap.
`timescale 1ns / 1ps
`default_nettype none

module smf_chain import smf_pkg::*; #(
  parameter int WINDOW = SMF_WINDOW
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         shift_i,
  input  wire logic                         clear_i,
  input  wire logic signed [SMF_DATA_W-1:0] sample_i,
  output logic signed [SMF_DATA_W-1:0]      median_o
);

  localparam int HALF_W = WINDOW / 2;

  localparam cell_link_t EDGE_LO = '{value: '0, age: '0, le: 1'b1, dl: 1'b0};
  localparam cell_link_t EDGE_HI = '{value: '0, age: '0, le: 1'b0, dl: 1'b1};

  cell_link_t           links   [WINDOW];
  cell_link_t           left_l  [WINDOW];
  cell_link_t           right_l [WINDOW];
  logic [WINDOW-1:0]    old_vec;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    if (i == 0) begin : g_lo
      assign left_l[i] = EDGE_LO;
    end else begin : g_lo_n
      assign left_l[i] = links[i-1];
    end
    if (i == WINDOW - 1) begin : g_hi
      assign right_l[i] = EDGE_HI;
    end else begin : g_hi_n
      assign right_l[i] = links[i+1];
    end

    smf_cell #(
      .WINDOW (WINDOW),
      .IDX    (i)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (shift_i),
      .clear_i  (clear_i),
      .sample_i (sample_i),
      .left_i   (left_l[i]),
      .right_i  (right_l[i]),
      .link_o   (links[i])
    );

    assign old_vec[i] = (links[i].age == SMF_AGE_W'(WINDOW - 1));
  end

  if ((WINDOW % 2) != 0) begin : g_odd
    assign median_o = links[HALF_W].value;
  end else begin : g_even
    logic signed [SMF_DATA_W:0] mid_sum;
    // floor of the mean of the two middle values
    assign mid_sum  = {links[HALF_W-1].value[SMF_DATA_W-1], links[HALF_W-1].value}
                    + {links[HALF_W].value[SMF_DATA_W-1], links[HALF_W].value};
    assign median_o = mid_sum[SMF_DATA_W:1];
  end

  // Ages stay a permutation, so exactly one cell is the oldest
  a_one_oldest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(old_vec))
    else $error("smf_chain: oldest entry not unique");

endmodule

`default_nettype wire

### sim/smf_median_checker.sv
// Checker for the sliding median filter: watches both channels, predicts and compares.
`timescale 1ns / 1ps

module smf_median_checker import smf_pkg::*; #(
  parameter int WINDOW = SMF_WINDOW
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic signed [SMF_DATA_W-1:0] sample_i,
  input  logic                         column_last_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic signed [SMF_DATA_W-1:0] filtered_i,
  input  logic                         run_last_i,
  input  logic                         column_end_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o
);

  localparam int HALF    = WINDOW / 2;
  localparam int LAG     = WINDOW - 1 - HALF;
  localparam int MAX_RES = LAG + 1;

  typedef struct packed {
    logic signed [SMF_DATA_W-1:0] filtered;
    logic                         run_last;
    logic                         column_end;
  } median_result_t;

  median_result_t               expected_medians[$];
  logic signed [SMF_DATA_W-1:0] win_q [WINDOW];
  int                           fill_q;
  logic signed [SMF_DATA_W-1:0] step_vals [MAX_RES];
  int                           step_n;
  int unsigned                  fails = 0;

  assign fail_count_o = fails;

  // Rank-based selection; ties broken by position so every rank is taken once.
  function automatic logic signed [SMF_DATA_W-1:0] window_median();
    int                         rank;
    logic signed [SMF_DATA_W:0] lo;
    logic signed [SMF_DATA_W:0] hi;
    logic signed [SMF_DATA_W:0] sum;
    lo = '0;
    hi = '0;
    for (int i = 0; i < WINDOW; i++) begin
      rank = 0;
      for (int j = 0; j < WINDOW; j++) begin
        if (win_q[j] < win_q[i] || (win_q[j] == win_q[i] && j < i)) rank++;
      end
      if (rank == HALF) hi = win_q[i];
      if (rank == HALF - 1) lo = win_q[i];
    end
    if ((WINDOW % 2) != 0) return hi[SMF_DATA_W-1:0];
    sum = (lo + hi) >>> 1;
    return sum[SMF_DATA_W-1:0];
  endfunction

  task automatic shift_in(input logic signed [SMF_DATA_W-1:0] x);
    for (int i = 0; i + 1 < WINDOW; i++) win_q[i] = win_q[i + 1];
    win_q[WINDOW-1] = x;
  endtask

  task automatic clear_window();
    for (int i = 0; i < WINDOW; i++) win_q[i] = '0;
    fill_q = 0;
  endtask

  task automatic predict_medians(input logic signed [SMF_DATA_W-1:0] x, input logic last);
    int             cnt;
    median_result_t r;
    step_n = 0;
    shift_in(x);
    if (fill_q < WINDOW) fill_q++;
    if (fill_q > LAG) begin
      step_vals[step_n] = window_median();
      step_n++;
    end
    if (last) begin
      // flush: trailing zero padding yields the pending positions
      cnt = fill_q;
      for (int s = 0; s < LAG; s++) begin
        shift_in('0);
        if (cnt < WINDOW) cnt++;
        if (cnt > LAG) begin
          step_vals[step_n] = window_median();
          step_n++;
        end
      end
      clear_window();
    end
    for (int k = 0; k < step_n; k++) begin
      r.filtered   = step_vals[k];
      r.run_last   = (k == step_n - 1);
      r.column_end = last && (k == step_n - 1);
      expected_medians.push_back(r);
    end
  endtask

  task automatic check_median();
    median_result_t want;
    if (expected_medians.size() == 0) begin
      $display("%0t: unexpected item: filtered %0d run_last %0b column_end %0b",
               $time, filtered_i, run_last_i, column_end_i);
      fails++;
    end else begin
      want = expected_medians.pop_front();
      if (want.filtered !== filtered_i) begin
        $display("%0t: filtered mismatch: expected %0d actual %0d",
                 $time, want.filtered, filtered_i);
        fails++;
      end
      if (want.run_last !== run_last_i) begin
        $display("%0t: run_last mismatch: expected %0b actual %0b",
                 $time, want.run_last, run_last_i);
        fails++;
      end
      if (want.column_end !== column_end_i) begin
        $display("%0t: column_end mismatch: expected %0b actual %0b",
                 $time, want.column_end, column_end_i);
        fails++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_window();
      expected_medians.delete();
      pending_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) predict_medians(sample_i, column_last_i);
      if (out_valid_i && !out_stall_i) check_median();
      pending_o <= expected_medians.size();
    end
  end

endmodule

### sim/tb_sliding_median_filter.sv
// Testbench top for the sliding median filter: stimulus, back pressure, watchdog, verdict.
`timescale 1ns / 1ps

module tb_sliding_median_filter import smf_pkg::*; ();

  localparam int N_ITEMS     = 420;
  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 90;
  localparam int DRAIN       = 4 * SMF_WINDOW + 10;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  in_valid      = 1'b0;
  logic [SMF_DATA_W-1:0] sample        = '0;
  logic                  column_last   = 1'b0;
  logic                  out_stall     = 1'b0;
  logic                  in_stall_o;
  logic                  out_valid_o;
  logic [SMF_DATA_W-1:0] filtered_o;
  logic                  run_last_o;
  logic                  column_end_o;

  int unsigned fail_count;
  int unsigned pending;
  int          items_sent   = 0;
  int          medians_seen = 0;
  int          idle_cycles  = 0;
  bit          send_burst   = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  sliding_median_filter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .sample_i      (sample),
    .column_last_i (column_last),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .filtered_o    (filtered_o),
    .run_last_o    (run_last_o),
    .column_end_o  (column_end_o)
  );

  smf_median_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall_o),
    .sample_i      (sample),
    .column_last_i (column_last),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall),
    .filtered_i    (filtered_o),
    .run_last_i    (run_last_o),
    .column_end_i  (column_end_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Mix of extremes, clustered small values (ties), whole numbers and full-range noise.
  function automatic logic [SMF_DATA_W-1:0] draw_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2, 3:    return 16'($urandom_range(0, 15) - 8);
      4:       return 16'($urandom_range(0, 4) * 16'h1000);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic [SMF_DATA_W-1:0] s, input logic last);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    sample      <= s;
    column_last <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  // Receiver: random stall per item, idle-free runs, and two long hold-offs.
  initial begin
    int  wait_n;
    bit  no_idle;
    no_idle = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (medians_seen % 16 == 0) no_idle = ($urandom_range(0, 3) == 0);
      wait_n = no_idle ? 0 : $urandom_range(0, 9);
      if (medians_seen == 40 || medians_seen == 300) wait_n = HOLD_CYCLES;
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk_i);
        out_stall <= 1'b0;
      end
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      medians_seen++;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("sliding_median_filter test failed");
      $finish;
    end
  end

  initial begin
    int len;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // single-sample columns at both extremes
    send_item(16'h7FFF, 1'b1);
    send_item(16'h8000, 1'b1);
    // two and three samples: flush outputs reach back to the column start
    send_item(16'h7FFF, 1'b0);
    send_item(16'h8000, 1'b1);
    send_item(16'h8000, 1'b0);
    send_item(16'h8000, 1'b0);
    send_item(16'h8000, 1'b1);
    // full window of the maximum; the zero padding leaves the ends at the maximum
    repeat (4) send_item(16'h7FFF, 1'b0);
    send_item(16'h7FFF, 1'b1);
    // mixed values with ties, back to back
    send_burst = 1'b1;
    send_item(16'h0001, 1'b0);
    send_item(16'hFFFF, 1'b0);
    send_item(16'h1000, 1'b0);
    send_item(16'h8000, 1'b0);
    send_item(16'h7FFF, 1'b0);
    send_item(16'h0005, 1'b0);
    send_item(16'h0005, 1'b1);
    send_burst = 1'b0;
    // alternating extremes
    for (int i = 0; i < 6; i++) send_item(i[0] ? 16'h8000 : 16'h7FFF, i == 5);

    while (items_sent < N_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       len = $urandom_range(1, 2);
        1:       len = $urandom_range(20, 40);
        default: len = $urandom_range(3, 12);
      endcase
      send_burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) send_item(draw_sample(), i == len - 1);
    end
    in_valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("sliding_median_filter test passed");
    end else begin
      $display("sliding_median_filter test failed");
    end
    $finish;
  end

endmodule

### files.f
src/smf_pkg.sv
src/smf_cell.sv
src/smf_chain.sv
src/sliding_median_filter.sv
sim/smf_median_checker.sv
sim/tb_sliding_median_filter.sv
